>>> src/srf_pkg.sv
// ----------------------------------------------------------------------------
// srf_pkg: speckle region filter shared definitions
// Widths, codes, defaults and sequencer states used across the filter.
// ----------------------------------------------------------------------------
`default_nettype none

package srf_pkg;

   localparam int MAX_COLS_DEF = 640;
   localparam int MAX_ROWS_DEF = 480;

   localparam int KIND_W     = 2;
   localparam int IDX_W      = 19;
   localparam int PIX_W      = 16;
   localparam int CNT_W      = 19;
   localparam int COLS_W     = 10;
   localparam int ROWS_W     = 9;
   localparam int DIFF_W     = 15;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 19;

   localparam logic [CNT_W-1:0] COUNT_MAX = '1;

   localparam logic [COLS_W-1:0] COLS_RST     = 10'd640;
   localparam logic [ROWS_W-1:0] ROWS_RST     = 9'd480;
   localparam logic [PIX_W-1:0]  MARKER_RST   = 16'd0;
   localparam logic [CNT_W-1:0]  MAX_SIZE_RST = 19'd100;
   localparam logic [DIFF_W-1:0] MAX_DIFF_RST = 15'd16;

   typedef enum logic [KIND_W-1:0] {
      REQ_WRITE   = 2'd0,
      REQ_RUN     = 2'd1,
      REQ_READ    = 2'd2,
      REQ_UNKNOWN = 2'd3
   } req_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_COLS     = 3'd0,
      REG_ROWS     = 3'd1,
      REG_MARKER   = 3'd2,
      REG_MAX_SIZE = 3'd3,
      REG_MAX_DIFF = 3'd4
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_WAIT,
      ST_INIT,
      ST_CLEAR,
      ST_SEED_RD,
      ST_SEED_CHK,
      ST_SEED_NEXT,
      ST_POP_RD,
      ST_POP_DAT,
      ST_PV_DAT,
      ST_NB_RD,
      ST_NB_CHK,
      ST_FILL_RD,
      ST_FILL_WR,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

>>> src/srf_if.sv
// ----------------------------------------------------------------------------
// srf_if: speckle region filter channels
// Request and response valid/ready channels with their payloads.
// ----------------------------------------------------------------------------
`default_nettype none

interface srf_req_if;
   import srf_pkg::*;
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   req_type;
   logic [IDX_W-1:0]    pixel_index;
   logic signed [PIX_W-1:0] pixel_value;
   modport source (output valid, output req_type, output pixel_index,
                   output pixel_value, input ready);
   modport sink   (input valid, input req_type, input pixel_index,
                   input pixel_value, output ready);
endinterface

interface srf_rsp_if;
   import srf_pkg::*;
   logic                valid;
   logic                ready;
   logic signed [PIX_W-1:0] read_value;
   logic [KIND_W-1:0]   done_kind;
   logic [CNT_W-1:0]    regions_removed;
   modport source (output valid, output read_value, output done_kind,
                   output regions_removed, input ready);
   modport sink   (input valid, input read_value, input done_kind,
                   input regions_removed, output ready);
endinterface

`default_nettype wire

>>> src/speckle_region_filter.sv
// ----------------------------------------------------------------------------
// speckle_region_filter: disparity speckle filter over a frame store
// Pixel write/read requests and filter runs with breadth-first region growth.
// ----------------------------------------------------------------------------
// A write or an unknown request is answered from idle; a read waits in a
// read-wait state for the registered frame data. A run has a setup step,
// clears the visited map over cols*rows entries, then scans the raster (read,
// check, next per pixel), plus for each pixel of a region a queue pop and pixel
// fetch, then up to four neighbor probes, each a read then a check (only the
// read for a probe off the edge); it then closes each region, overwrites a
// removed region pixel by pixel (read, write) and reports. All steps share
// single-port-read frame, visited and queue rams, so no request is taken
// during a run. The response is held in an output register; the next request
// is taken in the cycle that response is accepted, or at once if none waits.
`default_nettype none

module speckle_region_filter #(
   parameter int MAX_COLS = srf_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = srf_pkg::MAX_ROWS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   srf_req_if.sink                               req_chan,
   srf_rsp_if.source                             rsp_chan,
   input  wire logic                             csr_wr_en,
   input  wire logic [srf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [srf_pkg::CSR_DATA_W-1:0]   csr_wr_data
);
   import srf_pkg::*;

   localparam int DEPTH = MAX_COLS * MAX_ROWS;
   localparam int AW    = $clog2(DEPTH);
   localparam int TW    = $clog2(DEPTH + 1);
   localparam int CW    = $clog2(MAX_COLS);
   localparam int RW    = $clog2(MAX_ROWS);
   localparam int CNW   = $clog2(MAX_COLS + 1);
   localparam int RNW   = $clog2(MAX_ROWS + 1);

   typedef struct packed {
      logic [RW-1:0] row;
      logic [CW-1:0] col;
      logic [AW-1:0] idx;
   } qent_type;

   localparam int QW = $bits(qent_type);

   state_type state_ff, state_in;

   logic [COLS_W-1:0] cols_cfg_ff, cols_cfg_in;
   logic [ROWS_W-1:0] rows_cfg_ff, rows_cfg_in;
   logic [PIX_W-1:0]  marker_ff, marker_in;
   logic [CNT_W-1:0]  max_size_ff, max_size_in;
   logic [DIFF_W-1:0] max_diff_ff, max_diff_in;

   logic [CNW-1:0] cols_ff, cols_in;
   logic [RNW-1:0] rows_ff, rows_in;
   logic [TW-1:0]  total_ff, total_in;
   logic [AW-1:0]  clr_ff, clr_in;
   logic [AW-1:0]  seed_ff, seed_in;
   logic [RW-1:0]  srow_ff, srow_in;
   logic [CW-1:0]  scol_ff, scol_in;
   logic [TW-1:0]  head_ff, head_in;
   logic [TW-1:0]  tail_ff, tail_in;
   logic [TW-1:0]  fill_ff, fill_in;
   logic [1:0]     k_ff, k_in;
   qent_type       p_ff, p_in;
   qent_type       nb_ff, nb_in;
   logic [PIX_W-1:0] pv_ff, pv_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] removed_ff, removed_in;
   logic           rd_ok_ff, rd_ok_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0] rsp_value_ff, rsp_value_in;
   logic [KIND_W-1:0] rsp_kind_ff, rsp_kind_in;
   logic [CNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic             fr_we, vis_we, q_we;
   logic [AW-1:0]    fr_waddr, fr_raddr, vis_waddr, vis_raddr, q_waddr, q_raddr;
   logic [PIX_W-1:0] fr_wdata, fr_rdata;
   logic             vis_wdata, vis_rdata;
   qent_type         q_wdata, q_rdata;

   logic        req_ready, accept;
   logic        nb_in_bounds;
   qent_type    nb_ent;
   logic [16:0] diff, diff_abs;
   logic        region_done, seed_last;
   logic [CNW-1:0] cols_sat;
   logic [RNW-1:0] rows_sat;

   srf_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_frame (
      .clock(clock), .wr_en(fr_we), .wr_addr(fr_waddr), .wr_data(fr_wdata),
      .rd_addr(fr_raddr), .rd_data(fr_rdata));

   srf_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_visited (
      .clock(clock), .wr_en(vis_we), .wr_addr(vis_waddr), .wr_data(vis_wdata),
      .rd_addr(vis_raddr), .rd_data(vis_rdata));

   srf_ram #(.WIDTH(QW), .DEPTH(DEPTH)) u_queue (
      .clock(clock), .wr_en(q_we), .wr_addr(q_waddr), .wr_data(q_wdata),
      .rd_addr(q_raddr), .rd_data(q_rdata));

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign accept    = req_chan.valid && req_ready;
   assign req_chan.ready = req_ready;

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.read_value      = rsp_value_ff;
   assign rsp_chan.done_kind       = rsp_kind_ff;
   assign rsp_chan.regions_removed = rsp_count_ff;

   assign cols_sat = (cols_cfg_ff == '0) ? CNW'(1) :
                     (32'(cols_cfg_ff) > MAX_COLS) ? CNW'(MAX_COLS) : CNW'(cols_cfg_ff);
   assign rows_sat = (rows_cfg_ff == '0) ? RNW'(1) :
                     (32'(rows_cfg_ff) > MAX_ROWS) ? RNW'(MAX_ROWS) : RNW'(rows_cfg_ff);

   assign region_done = (head_ff == tail_ff);
   assign seed_last   = (TW'(seed_ff) + TW'(1) == total_ff);

   // neighbor of the popped pixel selected by k
   always_comb begin
      nb_ent       = p_ff;
      nb_in_bounds = 1'b0;
      case (k_ff)
         2'd0: begin
            nb_in_bounds = (p_ff.col != '0);
            nb_ent.col   = p_ff.col - CW'(1);
            nb_ent.idx   = p_ff.idx - AW'(1);
         end
         2'd1: begin
            nb_in_bounds = (CNW'(p_ff.col) + CNW'(1) < cols_ff);
            nb_ent.col   = p_ff.col + CW'(1);
            nb_ent.idx   = p_ff.idx + AW'(1);
         end
         2'd2: begin
            nb_in_bounds = (p_ff.row != '0);
            nb_ent.row   = p_ff.row - RW'(1);
            nb_ent.idx   = p_ff.idx - AW'(cols_ff);
         end
         default: begin
            nb_in_bounds = (RNW'(p_ff.row) + RNW'(1) < rows_ff);
            nb_ent.row   = p_ff.row + RW'(1);
            nb_ent.idx   = p_ff.idx + AW'(cols_ff);
         end
      endcase
   end

   assign diff     = {pv_ff[PIX_W-1], pv_ff} - {fr_rdata[PIX_W-1], fr_rdata};
   assign diff_abs = diff[16] ? (17'd0 - diff) : diff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_kind_type'(req_chan.req_type))
                  REQ_RUN:  state_in = ST_INIT;
                  REQ_READ: state_in = ST_RD_WAIT;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_RD_WAIT:   state_in = ST_IDLE;
         ST_INIT:      state_in = ST_CLEAR;
         ST_CLEAR:     if (TW'(clr_ff) + TW'(1) == total_ff) state_in = ST_SEED_RD;
         ST_SEED_RD:   state_in = ST_SEED_CHK;
         ST_SEED_CHK: begin
            if (fr_rdata != marker_ff && !vis_rdata) state_in = ST_POP_RD;
            else state_in = ST_SEED_NEXT;
         end
         ST_SEED_NEXT: state_in = seed_last ? ST_DONE : ST_SEED_RD;
         ST_POP_RD: begin
            if (!region_done) state_in = ST_POP_DAT;
            else if (32'(tail_ff) <= 32'(max_size_ff)) state_in = ST_FILL_RD;
            else state_in = ST_SEED_NEXT;
         end
         ST_POP_DAT:   state_in = ST_PV_DAT;
         ST_PV_DAT:    state_in = ST_NB_RD;
         ST_NB_RD: begin
            if (nb_in_bounds) state_in = ST_NB_CHK;
            else if (k_ff == 2'd3) state_in = ST_POP_RD;
         end
         ST_NB_CHK:    state_in = (k_ff == 2'd3) ? ST_POP_RD : ST_NB_RD;
         ST_FILL_RD:   state_in = ST_FILL_WR;
         ST_FILL_WR:   state_in = (fill_ff + TW'(1) == tail_ff) ? ST_SEED_NEXT : ST_FILL_RD;
         ST_DONE:      state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cols_cfg_in = cols_cfg_ff;
      rows_cfg_in = rows_cfg_ff;
      marker_in   = marker_ff;
      max_size_in = max_size_ff;
      max_diff_in = max_diff_ff;
      cols_in  = cols_ff;
      rows_in  = rows_ff;
      total_in = total_ff;
      clr_in   = clr_ff;
      seed_in  = seed_ff;
      srow_in  = srow_ff;
      scol_in  = scol_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      fill_in  = fill_ff;
      k_in     = k_ff;
      p_in     = p_ff;
      nb_in    = nb_ff;
      pv_in    = pv_ff;
      count_in = count_ff;
      removed_in = removed_ff;
      rd_ok_in = rd_ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in = rsp_value_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_count_in = rsp_count_ff;
      fr_we     = 1'b0;
      fr_waddr  = AW'(req_chan.pixel_index);
      fr_wdata  = req_chan.pixel_value;
      fr_raddr  = AW'(req_chan.pixel_index);
      vis_we    = 1'b0;
      vis_waddr = clr_ff;
      vis_wdata = 1'b0;
      vis_raddr = seed_ff;
      q_we      = 1'b0;
      q_waddr   = tail_ff[AW-1:0];
      q_wdata   = nb_ff;
      q_raddr   = head_ff[AW-1:0];

      if (csr_wr_en) begin
         case (csr_index)
            REG_COLS:     cols_cfg_in = csr_wr_data[COLS_W-1:0];
            REG_ROWS:     rows_cfg_in = csr_wr_data[ROWS_W-1:0];
            REG_MARKER:   marker_in   = csr_wr_data[PIX_W-1:0];
            REG_MAX_SIZE: max_size_in = csr_wr_data[CNT_W-1:0];
            REG_MAX_DIFF: max_diff_in = csr_wr_data[DIFF_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_kind_in  = req_chan.req_type;
               rsp_value_in = '0;
               rsp_count_in = removed_ff;
               rd_ok_in     = (32'(req_chan.pixel_index) < DEPTH);
               case (req_kind_type'(req_chan.req_type))
                  REQ_WRITE: begin
                     fr_we        = (32'(req_chan.pixel_index) < DEPTH);
                     rsp_valid_in = 1'b1;
                  end
                  REQ_RUN: begin
                     cols_in  = cols_sat;
                     rows_in  = rows_sat;
                     count_in = '0;
                  end
                  REQ_READ: ;
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         ST_RD_WAIT: begin
            rsp_value_in = rd_ok_ff ? fr_rdata : '0;
            rsp_valid_in = 1'b1;
         end
         ST_INIT: begin
            total_in = TW'(cols_ff) * TW'(rows_ff);
            clr_in   = '0;
         end
         ST_CLEAR: begin
            vis_we  = 1'b1;
            clr_in  = clr_ff + AW'(1);
            seed_in = '0;
            srow_in = '0;
            scol_in = '0;
         end
         ST_SEED_RD: begin
            fr_raddr  = seed_ff;
            vis_raddr = seed_ff;
         end
         ST_SEED_CHK: begin
            if (fr_rdata != marker_ff && !vis_rdata) begin
               vis_we    = 1'b1;
               vis_waddr = seed_ff;
               vis_wdata = 1'b1;
               q_we      = 1'b1;
               q_waddr   = '0;
               q_wdata   = '{row: srow_ff, col: scol_ff, idx: seed_ff};
               tail_in   = TW'(1);
               head_in   = '0;
            end
         end
         ST_SEED_NEXT: begin
            seed_in = seed_ff + AW'(1);
            if (CNW'(scol_ff) + CNW'(1) == cols_ff) begin
               scol_in = '0;
               srow_in = srow_ff + RW'(1);
            end else begin
               scol_in = scol_ff + CW'(1);
            end
         end
         ST_POP_RD: begin
            q_raddr = head_ff[AW-1:0];
            fill_in = '0;
            if (!region_done) head_in = head_ff + TW'(1);
         end
         ST_POP_DAT: begin
            p_in     = q_rdata;
            fr_raddr = q_rdata.idx;
            k_in     = '0;
         end
         ST_PV_DAT: pv_in = fr_rdata;
         ST_NB_RD: begin
            fr_raddr  = nb_ent.idx;
            vis_raddr = nb_ent.idx;
            nb_in     = nb_ent;
            if (!nb_in_bounds) k_in = k_ff + 2'd1;
         end
         ST_NB_CHK: begin
            if (!vis_rdata && fr_rdata != marker_ff &&
                diff_abs <= {2'b00, max_diff_ff}) begin
               vis_we    = 1'b1;
               vis_waddr = nb_ff.idx;
               vis_wdata = 1'b1;
               q_we      = 1'b1;
               tail_in   = tail_ff + TW'(1);
            end
            k_in = k_ff + 2'd1;
         end
         ST_FILL_RD: q_raddr = fill_ff[AW-1:0];
         ST_FILL_WR: begin
            fr_we    = 1'b1;
            fr_waddr = q_rdata.idx;
            fr_wdata = marker_ff;
            fill_in  = fill_ff + TW'(1);
            if (fill_ff + TW'(1) == tail_ff && count_ff != COUNT_MAX)
               count_in = count_ff + CNT_W'(1);
         end
         ST_DONE: begin
            removed_in   = count_ff;
            rsp_count_in = count_ff;
            rsp_value_in = '0;
            rsp_valid_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cols_cfg_ff  <= COLS_RST;
         rows_cfg_ff  <= ROWS_RST;
         marker_ff    <= MARKER_RST;
         max_size_ff  <= MAX_SIZE_RST;
         max_diff_ff  <= MAX_DIFF_RST;
         removed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cols_cfg_ff  <= cols_cfg_in;
         rows_cfg_ff  <= rows_cfg_in;
         marker_ff    <= marker_in;
         max_size_ff  <= max_size_in;
         max_diff_ff  <= max_diff_in;
         removed_ff   <= removed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cols_ff      <= cols_in;
      rows_ff      <= rows_in;
      total_ff     <= total_in;
      clr_ff       <= clr_in;
      seed_ff      <= seed_in;
      srow_ff      <= srow_in;
      scol_ff      <= scol_in;
      head_ff      <= head_in;
      tail_ff      <= tail_in;
      fill_ff      <= fill_in;
      k_ff         <= k_in;
      p_ff         <= p_in;
      nb_ff        <= nb_in;
      pv_ff        <= pv_in;
      count_ff     <= count_in;
      rd_ok_ff     <= rd_ok_in;
      rsp_value_ff <= rsp_value_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_count_ff <= rsp_count_in;
   end

endmodule

`default_nettype wire

>>> src/srf_ram.sv
// ----------------------------------------------------------------------------
// srf_ram: generic simple dual-port ram
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module srf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: speckle region filter testbench
// Loads small frames, runs the filter under many settings and reads pixels
// back. A scoreboard predicts every response beat and compares field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   import srf_pkg::*;

   localparam int STORE_DEPTH = MAX_COLS_DEF * MAX_ROWS_DEF;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int ITEM_TARGET = 550;

   typedef struct {
      logic [PIX_W-1:0] read_value;
      logic [KIND_W-1:0] done_kind;
      logic [CNT_W-1:0] regions_removed;
   } speckle_result_type;

   class speckle_scoreboard;
      logic [PIX_W-1:0] frame [int];
      int cols = COLS_RST;
      int rows = ROWS_RST;
      logic [PIX_W-1:0] marker = MARKER_RST;
      int max_size = MAX_SIZE_RST;
      int max_diff = MAX_DIFF_RST;
      int removed_count = 0;
      speckle_result_type pending [$];
      int errors = 0;
      int checked = 0;
      int runs = 0;
      int regions_total = 0;

      function void write_reg(reg_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_COLS:     cols = data[COLS_W-1:0];
            REG_ROWS:     rows = data[ROWS_W-1:0];
            REG_MARKER:   marker = data[PIX_W-1:0];
            REG_MAX_SIZE: max_size = data[CNT_W-1:0];
            REG_MAX_DIFF: max_diff = data[DIFF_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [PIX_W-1:0] pixel(int idx);
         return frame.exists(idx) ? frame[idx] : '0;
      endfunction

      function void filter_frame();
         int c, r, total, cnt, head, p, pr, pc, pv, nc, nr, n, d;
         bit seen [];
         int region [$];
         c = (cols < 1) ? 1 : (cols > MAX_COLS_DEF ? MAX_COLS_DEF : cols);
         r = (rows < 1) ? 1 : (rows > MAX_ROWS_DEF ? MAX_ROWS_DEF : rows);
         total = c * r;
         cnt = 0;
         seen = new[total];
         for (int seed = 0; seed < total; seed++) begin
            if (pixel(seed) == marker || seen[seed]) continue;
            seen[seed] = 1;
            region = {seed};
            head = 0;
            while (head < region.size()) begin
               p = region[head];
               head++;
               pr = p / c;
               pc = p % c;
               pv = $signed(pixel(p));
               for (int k = 0; k < 4; k++) begin
                  nc = pc + ((k == 0) ? -1 : (k == 1) ? 1 : 0);
                  nr = pr + ((k == 2) ? -1 : (k == 3) ? 1 : 0);
                  if (nc < 0 || nc >= c || nr < 0 || nr >= r) continue;
                  n = nr * c + nc;
                  if (seen[n] || pixel(n) == marker) continue;
                  d = pv - int'($signed(pixel(n)));
                  if (d < 0) d = -d;
                  if (d <= max_diff) begin
                     seen[n] = 1;
                     region = {region, n};
                  end
               end
            end
            if (region.size() <= max_size) begin
               foreach (region[i]) frame[region[i]] = marker;
               if (cnt < int'(COUNT_MAX)) cnt++;
            end
         end
         removed_count = cnt;
         runs++;
         regions_total += cnt;
      endfunction

      function void note_request(logic [KIND_W-1:0] kind, int idx, logic [PIX_W-1:0] val);
         speckle_result_type res;
         res.read_value = '0;
         case (req_kind_type'(kind))
            REQ_WRITE: if (idx < STORE_DEPTH) frame[idx] = val;
            REQ_RUN:   filter_frame();
            REQ_READ:  if (idx < STORE_DEPTH) res.read_value = pixel(idx);
            default: ;
         endcase
         res.done_kind = kind;
         res.regions_removed = CNT_W'(removed_count);
         pending = {pending, res};
      endfunction

      function void check_response(logic [PIX_W-1:0] rd, logic [KIND_W-1:0] kind,
                                   logic [CNT_W-1:0] cnt);
         speckle_result_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected beat kind %0d value %h count %0d", $time, kind, rd, cnt);
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         if (rd !== e.read_value) begin
            $display("%0t: read_value expected %h actual %h", $time, e.read_value, rd);
            errors++;
         end
         if (kind !== e.done_kind) begin
            $display("%0t: done_kind expected %0d actual %0d", $time, e.done_kind, kind);
            errors++;
         end
         if (cnt !== e.regions_removed) begin
            $display("%0t: regions_removed expected %0d actual %0d", $time,
                     e.regions_removed, cnt);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_wr_en = 0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   srf_req_if req_chan ();
   srf_rsp_if rsp_chan ();

   speckle_region_filter DUT (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   speckle_scoreboard sb = new();
   int cycles = 0;
   int items = 0;
   int burst_left = 0;
   int hold_count = 0;
   bit hold_req = 0;
   int written [$];

   initial begin
      req_chan.valid = 0;
      req_chan.req_type = '0;
      req_chan.pixel_index = '0;
      req_chan.pixel_value = '0;
      rsp_chan.ready = 0;
   end

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("speckle_region_filter test failed");
         $finish;
      end
   end

   // receiver: one long hold-off on request, else a rotating stall pattern
   always @(posedge clock) begin
      if (hold_req) begin
         rsp_chan.ready <= 0;
         hold_count++;
         if (hold_count >= 400) begin
            hold_req = 0;
            hold_count = 0;
         end
      end else begin
         case ((cycles / 250) % 3)
            0: rsp_chan.ready <= 1;
            1: rsp_chan.ready <= $urandom_range(0, 1);
            default: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         sb.check_response(rsp_chan.read_value, rsp_chan.done_kind,
                           rsp_chan.regions_removed);
   end

   task automatic send_req(req_kind_type kind, int idx, logic [PIX_W-1:0] val);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_chan.valid <= 0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_chan.valid <= 1;
      req_chan.req_type <= kind;
      req_chan.pixel_index <= idx[IDX_W-1:0];
      req_chan.pixel_value <= val;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_request(kind, idx, val);
      if (kind == REQ_WRITE && idx < STORE_DEPTH) written = {written, idx};
      burst_left--;
      items++;
   endtask

   task automatic wait_idle();
      req_chan.valid <= 0;
      burst_left = 0;
      do @(posedge clock); while (sb.pending.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
      csr_wr_en <= 0;
      @(posedge clock);
   endtask

   task automatic set_regs(int c, int r, logic [PIX_W-1:0] mk, int size, int diff);
      write_reg(REG_COLS, CSR_DATA_W'(c));
      write_reg(REG_ROWS, CSR_DATA_W'(r));
      write_reg(REG_MARKER, {3'b000, mk});
      write_reg(REG_MAX_SIZE, CSR_DATA_W'(size));
      write_reg(REG_MAX_DIFF, CSR_DATA_W'(diff));
   endtask

   function automatic logic [PIX_W-1:0] pick_pixel(logic [PIX_W-1:0] base);
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 2) return sb.marker;
      if (sel < 7)
         return PIX_W'(base + $urandom_range(0, sb.max_diff > 40 ? 40 : sb.max_diff));
      if (sel < 8) return PIX_W'(base + sb.max_diff + 1);
      return PIX_W'($urandom_range(0, 16'hffff));
   endfunction

   task automatic noise();
      case ($urandom_range(0, 3))
         0: send_req(REQ_UNKNOWN, $urandom_range(0, 524287),
                     PIX_W'($urandom_range(0, 16'hffff)));
         1: send_req(REQ_WRITE, $urandom_range(STORE_DEPTH, 524287),
                     PIX_W'($urandom_range(0, 16'hffff)));
         2: send_req(REQ_READ, $urandom_range(STORE_DEPTH, 524287),
                     PIX_W'($urandom_range(0, 16'hffff)));
         default: send_req(REQ_READ, written[$urandom_range(0, written.size() - 1)],
                           PIX_W'($urandom_range(0, 16'hffff)));
      endcase
   endtask

   task automatic frame_phase(int c, int r, logic [PIX_W-1:0] mk, int size, int diff,
                              bit refill);
      int ec, er, total;
      logic [PIX_W-1:0] base;
      set_regs(c, r, mk, size, diff);
      ec = (c < 1) ? 1 : (c > MAX_COLS_DEF ? MAX_COLS_DEF : c);
      er = (r < 1) ? 1 : (r > MAX_ROWS_DEF ? MAX_ROWS_DEF : r);
      total = ec * er;
      base = PIX_W'($urandom_range(0, 16'hffff));
      if (refill)
         for (int i = 0; i < total; i++) begin
            if ($urandom_range(0, 12) == 0) base = PIX_W'($urandom_range(0, 16'hffff));
            send_req(REQ_WRITE, i, pick_pixel(base));
            if ($urandom_range(0, 9) == 0) noise();
         end
      send_req(REQ_RUN, $urandom_range(0, 524287), PIX_W'($urandom_range(0, 16'hffff)));
      repeat ($urandom_range(2, 8)) send_req(REQ_READ, $urandom_range(0, total - 1), '0);
      if ($urandom_range(0, 2) == 0)
         send_req(REQ_RUN, 0, '0);
      wait_idle();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed frame, 4 x 3, marker zero
      set_regs(4, 3, 16'h0000, 2, 16);
      send_req(REQ_WRITE, 0, 16'd100);
      send_req(REQ_WRITE, 1, 16'd116);
      send_req(REQ_WRITE, 2, 16'h7fff);
      send_req(REQ_WRITE, 3, 16'h0000);
      send_req(REQ_WRITE, 4, 16'd100);
      send_req(REQ_WRITE, 5, 16'h8000);
      send_req(REQ_WRITE, 6, 16'h7ff0);
      send_req(REQ_WRITE, 7, 16'd117);
      send_req(REQ_WRITE, 8, 16'd50);
      send_req(REQ_WRITE, 9, 16'd50);
      send_req(REQ_WRITE, 10, 16'd66);
      send_req(REQ_WRITE, 11, 16'd83);
      send_req(REQ_WRITE, STORE_DEPTH - 1, 16'h5a5a);
      send_req(REQ_WRITE, STORE_DEPTH, 16'h1234);
      send_req(REQ_WRITE, 524287, 16'hffff);
      send_req(REQ_READ, STORE_DEPTH - 1, 16'hffff);
      send_req(REQ_READ, STORE_DEPTH, '0);
      send_req(REQ_READ, 524287, '0);
      send_req(REQ_UNKNOWN, 0, 16'hffff);
      send_req(REQ_RUN, 0, '0);
      send_req(REQ_READ, 2, '0);
      send_req(REQ_READ, 5, '0);
      send_req(REQ_READ, 11, '0);
      wait_idle();

      hold_req = 1;
      frame_phase(5, 4, 16'h0000, 3, 16, 1);
      frame_phase(0, 7, 16'h8000, 0, 0, 1);
      frame_phase(8, 8, 16'h7fff, 307200, 32767, 1);
      frame_phase(6, 5, PIX_W'($urandom_range(0, 16'hffff)), 524287, 32767, 1);
      frame_phase(1023, 1, PIX_W'($urandom_range(0, 16'hffff)), 20, 60, 1);
      frame_phase(1, 511, PIX_W'($urandom_range(0, 16'hffff)), 5, 200, 0);
      while (items < ITEM_TARGET)
         frame_phase($urandom_range(0, 9), $urandom_range(1, 8),
                     PIX_W'($urandom_range(0, 16'hffff)),
                     $urandom_range(0, 6), $urandom_range(0, 80), 1);

      do @(posedge clock); while (sb.pending.size() != 0);
      repeat (50) @(posedge clock);
      $display("covered %0d requests, %0d filter runs removing %0d regions",
               items, sb.runs, sb.regions_total);
      $display("%0d response beats checked, %0d mismatches", sb.checked, sb.errors);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("speckle_region_filter test passed");
      else
         $display("speckle_region_filter test failed");
      $finish;
   end

endmodule

`default_nettype wire

>>> filelist.f
src/srf_pkg.sv
src/srf_if.sv
src/srf_ram.sv
src/speckle_region_filter.sv
tb/sv/tb.sv
